// ===== hw/rtl/crt_pkg.sv =====
// Shared types and constants for the custody range tracker.
// Holds the channel payload structs, status codes and compare-flag struct.
// No dependencies.
package crt_pkg;

    // Status codes reported with every result transaction.
    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_HELD    = 3'd1,
        ST_APPEND  = 3'd2,
        ST_MERGE   = 3'd3,
        ST_PREPEND = 3'd4,
        ST_NEW     = 3'd5,
        ST_FULL    = 3'd6
    } crt_status_t;

    // Input transaction payload.
    typedef struct packed {
        logic [31:0] xmit_id;
        logic [31:0] deadline;
    } crt_in_t;

    // Result transaction payload.
    typedef struct packed {
        crt_status_t status;
        logic [31:0] range_first;
        logic [31:0] range_last;
        logic [4:0]  range_count;
        logic [31:0] earliest_deadline;
    } crt_out_t;

    // Relations between the current id and one table entry.
    typedef struct packed {
        logic lt_first;   // entry first < id
        logic ge_last;    // entry last >= id
        logic last_adj;   // entry last + 1 == id
        logic first_eq;   // entry first == id
        logic first_adj;  // entry first == id + 1
    } crt_flags_t;

endpackage

// ===== hw/rtl/custody_range_tracker_top.sv =====
// Sequence: an id of zero goes straight to the result; any other id walks the table from
// entry 0 until it stops, and an insert or merge then moves the table entries that follow.
// The walk and the entry moves go one table entry per cycle through the single read port.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset (rst_n low, asynchronous) empties the table and sets the earliest deadline to
// all ones; table contents are not cleared.
module custody_range_tracker_top #(
    parameter int MAX_RANGES = 16,
    parameter int ID_BITS    = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  crt_pkg::crt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output crt_pkg::crt_out_t out_data
);

    localparam int IW = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = 2 * IW;

    localparam logic [CW:0] C_ONE = (CW + 1)'(1);
    localparam logic [CW:0] C_TWO = (CW + 1)'(2);
    localparam logic [CW:0] C_MAX = (CW + 1)'(MAX_RANGES);

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_WALK = 8'b0000_0010,
        S_MCHK = 8'b0000_0100,
        S_SHDN = 8'b0000_1000,
        S_NEW  = 8'b0001_0000,
        S_SHUP = 8'b0010_0000,
        S_WNEW = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } crt_state_t;

    crt_state_t state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [31:0]   soonest_reg, soonest_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic          out_valid_reg, out_valid_next;

    logic [IW-1:0]        id_reg, id_next;
    logic [31:0]          dl_reg, dl_next;
    logic [IW-1:0]        keep_first_reg, keep_first_next;
    crt_pkg::crt_status_t res_status_reg, res_status_next;
    logic [IW-1:0]        res_first_reg, res_first_next;
    logic [IW-1:0]        res_last_reg, res_last_next;
    crt_pkg::crt_out_t    out_data_reg, out_data_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data;
    logic [IW-1:0]       rd_first;
    logic [IW-1:0]       rd_last;
    crt_pkg::crt_flags_t flags;

    logic [CW:0] used_w;
    logic [CW:0] lim_w;
    logic [CW:0] pos_w;
    logic [CW:0] idx_w;
    logic [CW:0] pos_p1;
    logic [CW:0] pos_p2;
    logic [CW:0] idx_p1;
    logic [CW:0] idx_p2;
    logic [CW:0] idx_m1;
    logic [CW:0] idx_m2;
    logic [CW:0] used_m1;
    logic [31:0] new_dl;

    // Range table and shared compare unit.
    crt_table #(
        .DEPTH (MAX_RANGES),
        .AW    (AW),
        .WIDTH (EW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_first = rd_data[EW-1:IW];
    assign rd_last  = rd_data[IW-1:0];

    crt_cmp #(
        .IW (IW)
    ) u_cmp (
        .id    (id_reg),
        .first (rd_first),
        .last  (rd_last),
        .flags (flags)
    );

    // Index arithmetic, one bit wider than the counters.
    assign used_w  = {1'b0, used_reg};
    assign lim_w   = {1'b0, lim_reg};
    assign pos_w   = {1'b0, pos_reg};
    assign idx_w   = {1'b0, idx_reg};
    assign pos_p1  = pos_w + C_ONE;
    assign pos_p2  = pos_w + C_TWO;
    assign idx_p1  = idx_w + C_ONE;
    assign idx_p2  = idx_w + C_TWO;
    assign idx_m1  = idx_w - C_ONE;
    assign idx_m2  = idx_w - C_TWO;
    assign used_m1 = used_w - C_ONE;

    assign new_dl = (dl_reg < soonest_reg) ? dl_reg : soonest_reg;

    // Sequencer: walks the table, then moves entries to insert or merge.
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        soonest_next    = soonest_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        id_next         = id_reg;
        dl_next         = dl_reg;
        keep_first_next = keep_first_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg[AW-1:0];
        wr_data         = {id_reg, id_reg};
        rd_en           = 1'b0;
        rd_addr         = pos_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next  = in_data.xmit_id[IW-1:0];
                    dl_next  = in_data.deadline;
                    pos_next = '0;
                    if (in_data.xmit_id[IW-1:0] == '0)
                    begin
                        res_status_next = crt_pkg::ST_IGNORED;
                        res_first_next  = '0;
                        res_last_next   = '0;
                        state_next      = S_FIN;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = S_NEW;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_WALK;
                    end
                end
            end

            // Read data holds entry pos_reg.
            S_WALK:
            begin
                if (flags.lt_first)
                begin
                    if (flags.ge_last)
                    begin
                        soonest_next    = new_dl;
                        res_status_next = crt_pkg::ST_HELD;
                        res_first_next  = rd_first;
                        res_last_next   = rd_last;
                        state_next      = S_FIN;
                    end
                    else if (flags.last_adj)
                    begin
                        soonest_next    = new_dl;
                        keep_first_next = rd_first;
                        if (pos_p1 < used_w)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_p1[AW-1:0];
                            state_next = S_MCHK;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_data         = {rd_first, id_reg};
                            res_status_next = crt_pkg::ST_APPEND;
                            res_first_next  = rd_first;
                            res_last_next   = id_reg;
                            state_next      = S_FIN;
                        end
                    end
                    else
                    begin
                        pos_next = pos_p1[CW-1:0];
                        if (pos_p1 < used_w)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = pos_p1[AW-1:0];
                        end
                        else
                        begin
                            state_next = S_NEW;
                        end
                    end
                end
                else if (flags.first_eq)
                begin
                    soonest_next    = new_dl;
                    res_status_next = crt_pkg::ST_HELD;
                    res_first_next  = rd_first;
                    res_last_next   = rd_last;
                    state_next      = S_FIN;
                end
                else if (flags.first_adj)
                begin
                    soonest_next    = new_dl;
                    wr_en           = 1'b1;
                    wr_data         = {id_reg, rd_last};
                    res_status_next = crt_pkg::ST_PREPEND;
                    res_first_next  = id_reg;
                    res_last_next   = rd_last;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end

            // Read data holds the entry after the one just appended to.
            S_MCHK:
            begin
                wr_en = 1'b1;
                if (flags.first_adj)
                begin
                    wr_data         = {keep_first_reg, rd_last};
                    res_status_next = crt_pkg::ST_MERGE;
                    res_first_next  = keep_first_reg;
                    res_last_next   = rd_last;
                    used_next       = used_m1[CW-1:0];
                    lim_next        = used_reg;
                    idx_next        = pos_p1[CW-1:0];
                    if (pos_p2 < used_w)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_p2[AW-1:0];
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    wr_data         = {keep_first_reg, id_reg};
                    res_status_next = crt_pkg::ST_APPEND;
                    res_first_next  = keep_first_reg;
                    res_last_next   = id_reg;
                    state_next      = S_FIN;
                end
            end

            // Close the gap left by a merge: entry idx takes entry idx+1.
            S_SHDN:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_p1[CW-1:0];
                if (idx_p2 < lim_w)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p2[AW-1:0];
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // A new range is needed at pos_reg.
            S_NEW:
            begin
                if (used_w >= C_MAX)
                begin
                    res_status_next = crt_pkg::ST_FULL;
                    res_first_next  = '0;
                    res_last_next   = '0;
                    state_next      = S_FIN;
                end
                else
                begin
                    soonest_next = new_dl;
                    used_next    = used_reg + {{(CW - 1){1'b0}}, 1'b1};
                    idx_next     = used_reg;
                    if (used_reg > pos_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = used_m1[AW-1:0];
                        state_next = S_SHUP;
                    end
                    else
                    begin
                        state_next = S_WNEW;
                    end
                end
            end

            // Open a slot: entry idx takes entry idx-1.
            S_SHUP:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_m1[CW-1:0];
                if (idx_m1 > pos_w)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m2[AW-1:0];
                end
                else
                begin
                    state_next = S_WNEW;
                end
            end

            S_WNEW:
            begin
                wr_en           = 1'b1;
                wr_data         = {id_reg, id_reg};
                res_status_next = crt_pkg::ST_NEW;
                res_first_next  = id_reg;
                res_last_next   = id_reg;
                state_next      = S_FIN;
            end

            // Hand the result to the output register once it is free.
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.status            = res_status_reg;
                    out_data_next.range_first       = 32'(res_first_reg);
                    out_data_next.range_last        = 32'(res_last_reg);
                    out_data_next.range_count       = 5'(used_reg);
                    out_data_next.earliest_deadline = soonest_reg;
                    state_next                      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            soonest_reg   <= '1;
            pos_reg       <= '0;
            idx_reg       <= '0;
            lim_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            soonest_reg   <= soonest_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        dl_reg         <= dl_next;
        keep_first_reg <= keep_first_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        out_data_reg   <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/crt_table.sv =====
// Range table storage: one write port and one read port with registered data.
// Each word holds a range's first id in the upper half and last id in the lower.
// Depends on nothing.
module crt_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/crt_cmp.sv =====
// Shared compare unit: relates the current id to the entry just read.
// The sequencer's decisions on table entries are taken from these flags.
// Depends on crt_pkg.
module crt_cmp #(
    parameter int IW = 32
) (
    input  logic [IW-1:0]       id,
    input  logic [IW-1:0]       first,
    input  logic [IW-1:0]       last,
    output crt_pkg::crt_flags_t flags
);

    logic [IW:0] id_inc;
    logic [IW:0] last_inc;

    // Increments are one bit wider so the top id never wraps to zero.
    assign id_inc   = {1'b0, id} + {{IW{1'b0}}, 1'b1};
    assign last_inc = {1'b0, last} + {{IW{1'b0}}, 1'b1};

    assign flags.lt_first  = (first < id);
    assign flags.ge_last   = (last >= id);
    assign flags.last_adj  = (last_inc == {1'b0, id});
    assign flags.first_eq  = (first == id);
    assign flags.first_adj = ({1'b0, first} == id_inc);

endmodule

// ===== hw/rtl/crt_checker.sv =====
// Port-level checker for the custody range tracker, bound to the top level.
// Depends on crt_pkg and custody_range_tracker_top.
module crt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input crt_pkg::crt_out_t out_data
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One input transaction at a time: not ready right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Ignored and full results carry an empty range.
    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == crt_pkg::ST_IGNORED ||
                      out_data.status == crt_pkg::ST_FULL)
        |-> out_data.range_first == '0 && out_data.range_last == '0)
        else $error("non-empty range on ignored or full result");

    // A new range holds exactly one nonzero id and at least one range exists.
    a_new_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == crt_pkg::ST_NEW
        |-> out_data.range_first == out_data.range_last &&
            out_data.range_first != '0 && out_data.range_count != '0)
        else $error("malformed new range result");

endmodule

bind custody_range_tracker_top crt_checker u_crt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
